// ----- design/siphash_2_4_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// SipHash-2-4 engine assertion macros
// Clocked, reset-gated property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SIPHASH_2_4_ENGINE_TOP_MACROS_SVH
`define SIPHASH_2_4_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define SIP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("siphash engine check failed");

// next-cycle implication
`define SIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("siphash engine check failed");

`endif

// ----- design/sip24_pkg.sv -----
// ----------------------------------------------------------------------------
// SipHash-2-4 package
// Lane type, sequencer states, register indexes, constants and round logic.
// ----------------------------------------------------------------------------
`default_nettype none

package sip24_pkg;

	localparam logic [63:0] C0 = 64'h736f6d6570736575;
	localparam logic [63:0] C1 = 64'h646f72616e646f6d;
	localparam logic [63:0] C2 = 64'h6c7967656e657261;
	localparam logic [63:0] C3 = 64'h7465646279746573;
	localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

	localparam int unsigned ADDR_W = 5;

	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_REDUCE   = 2'd2;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} lanes_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_LEN,
		ST_FIN1,
		ST_FIN2
	} state_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic lanes_t sip_round(input lanes_t a);
		lanes_t b;
		b = a;
		b.v0 = b.v0 + b.v1;
		b.v1 = rotl(b.v1, 13) ^ b.v0;
		b.v0 = rotl(b.v0, 32);
		b.v2 = b.v2 + b.v3;
		b.v3 = rotl(b.v3, 16) ^ b.v2;
		b.v0 = b.v0 + b.v3;
		b.v3 = rotl(b.v3, 21) ^ b.v0;
		b.v2 = b.v2 + b.v1;
		b.v1 = rotl(b.v1, 17) ^ b.v2;
		b.v2 = rotl(b.v2, 32);
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- design/siphash_2_4_engine_top.sv -----
// ----------------------------------------------------------------------------
// SipHash-2-4 engine
// Keyed SipHash-2-4 over a stream of 64-bit little-endian message words.
// ----------------------------------------------------------------------------
// Throughput: one message word per cycle; two SipRounds per cycle set the pace.
// The last item moves from the input register through ST_RUN, ST_LEN (only
// when it holds 8 bytes in byte mode and a length-only word follows), ST_FIN1
// and ST_FIN2, where the hash is registered. Between messages the input stalls
// while finalization runs, longer while the previous hash waits on the output.
// Reset: arst_n clears keys, mode, control and valid flags asynchronously.
`default_nettype none

module siphash_2_4_engine_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// s_axis_tdata: [63:0] message_word, [67:64] byte_count, [71:68] zero
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	input  wire logic [71:0]                   s_axis_tdata,
	input  wire logic                          s_axis_tlast,
	// m_axis_tdata: [63:0] hash_value
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output      logic [63:0]                   m_axis_tdata,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sip24_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [63:0]                   pwdata,
	output      logic [63:0]                   prdata,
	output      logic                          pready
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        reduce_q;

	logic        valid_s1;
	logic [63:0] word_s1;
	logic [3:0]  count_s1;
	logic        last_s1;

	sip24_pkg::state_t state_q, state_d;
	sip24_pkg::lanes_t lanes_q, lanes_base, rin, rout;
	logic        in_msg_q;
	logic [7:0]  len_q, len_base, len_full, len_part;
	logic [63:0] m_sel, mask;
	logic        consume, fin_go, lane_en, wr_en;
	logic        out_valid_q;
	logic [63:0] hash_q;

	// configuration port
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			reduce_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				sip24_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				sip24_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				sip24_pkg::REG_REDUCE:   reduce_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			sip24_pkg::REG_KEY_LOW:  prdata = key_low_q;
			sip24_pkg::REG_KEY_HIGH: prdata = key_high_q;
			sip24_pkg::REG_REDUCE:   prdata = {63'd0, reduce_q};
			default:                 prdata = '0;
		endcase
	end

	// input register
	assign consume       = (state_q == sip24_pkg::ST_RUN) && valid_s1;
	assign s_axis_tready = !valid_s1 || (state_q == sip24_pkg::ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			word_s1  <= s_axis_tdata[63:0];
			count_s1 <= s_axis_tdata[67:64];
			last_s1  <= s_axis_tlast;
		end
	end

	// lanes start from the key at the first word of a message
	always_comb begin
		if (in_msg_q) begin
			lanes_base = lanes_q;
			len_base   = len_q;
		end else begin
			lanes_base.v0 = key_low_q ^ sip24_pkg::C0;
			lanes_base.v1 = key_high_q ^ sip24_pkg::C1;
			lanes_base.v2 = key_low_q ^ sip24_pkg::C2;
			lanes_base.v3 = key_high_q ^ sip24_pkg::C3;
			len_base      = 8'd0;
		end
	end

	assign len_full = len_base + 8'd8;
	assign len_part = len_base + {5'd0, count_s1[2:0]};
	assign mask     = (64'd1 << {count_s1[2:0], 3'b000}) - 64'd1;

	// select round input and message word, then two shared SipRounds
	always_comb begin
		rin   = lanes_q;
		m_sel = '0;
		unique case (state_q)
			sip24_pkg::ST_RUN: begin
				rin = lanes_base;
				if (last_s1 && !reduce_q && !count_s1[3]) begin
					m_sel = (word_s1 & mask) | {len_part, 56'd0};
				end else begin
					m_sel = word_s1;
				end
			end
			sip24_pkg::ST_LEN:  m_sel = {len_q, 56'd0};
			sip24_pkg::ST_FIN1: rin.v2 = lanes_q.v2 ^ sip24_pkg::FIN_XOR;
			sip24_pkg::ST_FIN2: ;
		endcase
		rin.v3  = rin.v3 ^ m_sel;
		rout    = sip24_pkg::sip_round(sip24_pkg::sip_round(rin));
		rout.v0 = rout.v0 ^ m_sel;
	end

	assign fin_go = (state_q == sip24_pkg::ST_FIN2) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		lane_en = 1'b0;
		unique case (state_q)
			sip24_pkg::ST_RUN: begin
				lane_en = valid_s1;
				if (valid_s1 && last_s1) begin
					if (!reduce_q && count_s1[3]) begin
						state_d = sip24_pkg::ST_LEN;
					end else begin
						state_d = sip24_pkg::ST_FIN1;
					end
				end
			end
			sip24_pkg::ST_LEN: begin
				lane_en = 1'b1;
				state_d = sip24_pkg::ST_FIN1;
			end
			sip24_pkg::ST_FIN1: begin
				lane_en = 1'b1;
				state_d = sip24_pkg::ST_FIN2;
			end
			sip24_pkg::ST_FIN2: begin
				lane_en = fin_go;
				if (fin_go) begin
					state_d = sip24_pkg::ST_RUN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sip24_pkg::ST_RUN;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (consume) begin
				in_msg_q <= !last_s1;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lane_en) begin
			lanes_q <= rout;
		end
		if (consume) begin
			len_q <= (last_s1 && !count_s1[3]) ? len_part : len_full;
		end
		if (fin_go) begin
			hash_q <= rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = hash_q;

endmodule

`default_nettype wire

// ----- design/sip24_checker.sv -----
// ----------------------------------------------------------------------------
// SipHash-2-4 engine port checker
// Watches the top-level ports for stream, config and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "siphash_2_4_engine_top_macros.svh"

module sip24_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          s_axis_tlast,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [63:0]                   m_axis_tdata,
	input wire logic                          psel,
	input wire logic                          penable,
	input wire logic                          pwrite,
	input wire logic [sip24_pkg::ADDR_W-1:0]  paddr,
	input wire logic [63:0]                   pwdata,
	input wire logic [63:0]                   prdata,
	input wire logic                          pready
);

	logic s_acc;
	logic key_wr;

	assign s_acc  = s_axis_tvalid && s_axis_tready;
	assign key_wr = psel && penable && pwrite && pready
		&& (paddr[4:3] == sip24_pkg::REG_KEY_LOW);

	// a stalled result holds
	`SIP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// the port never inserts wait states
	`SIP_ASSERT_NOW(a_pready, 1'b1, pready)

	// a word queued behind a last item waits while finalization runs
	`SIP_ASSERT_NEXT(a_fin_stall, s_acc && s_axis_tlast ##1 s_acc, !s_axis_tready)

	// a low-key write reads back on the next cycle
	`SIP_ASSERT_NEXT(a_key_readback, key_wr,
		!(psel && !pwrite && (paddr[4:3] == sip24_pkg::REG_KEY_LOW))
		|| (prdata == $past(pwdata)))

endmodule

bind siphash_2_4_engine_top sip24_checker u_sip24_checker (.*);

`default_nettype wire
